// ----- sv/hfc_pkg.sv -----
// ----------------------------------------------------------------------------
// hfc_pkg
// Shared types and constants for the binary32/binary16 converter.
// ----------------------------------------------------------------------------
`default_nettype none
package hfc_pkg;
  localparam logic CMD_NARROW = 1'b0;
  localparam logic CMD_WIDEN  = 1'b1;

  // decoded and aligned item between stage 1 and stage 2
  typedef struct packed {
    logic        cmd;
    logic        last;
    logic        sign;
    // narrowing
    logic        n_special;  // inf/nan
    logic        n_nan;
    logic        n_ovf;
    logic        n_normal;
    logic        n_zero;
    logic [7:0]  exp;
    logic [22:0] frac;
    logic [14:0] q;          // subnormal significand after the shift
    logic [23:0] rem;        // bits shifted out
    logic [23:0] half;       // halfway weight for the shift
    // widening
    logic [15:0] h;
    logic [3:0]  p;          // leading one of the half fraction
    logic [9:0]  mn;         // normalized subnormal fraction
  } dec_t;

  // rounding decided, between stage 2 and stage 3
  typedef struct packed {
    logic        cmd;
    logic        last;
    logic        sign;
    logic [14:0] npre;       // narrowed magnitude before the increment
    logic        ninc;       // round up
    logic [30:0] wres;       // widened magnitude
  } res_t;
endpackage
`default_nettype wire

// ----- sv/hfc_if.sv -----
// ----------------------------------------------------------------------------
// hfc_if
// Valid/ready channel carrying converter items.
// ----------------------------------------------------------------------------
`default_nettype none
interface hfc_if #(
  parameter int W = 32
);
  logic         valid;
  logic         ready;
  logic         cmd;
  logic [W-1:0] data;
  logic         last;
  modport source (output valid, output cmd, output data, output last, input ready);
  modport sink   (input valid, input cmd, input data, input last, output ready);
endinterface
`default_nettype wire

// ----- sv/hfc_decode.sv -----
// ----------------------------------------------------------------------------
// hfc_decode
// Stage 1: field split, range classification, subnormal alignment and
// leading-one search.
// ----------------------------------------------------------------------------
`default_nettype none
module hfc_decode (
  input  wire logic          cmd,
  input  wire logic [31:0]   data,
  input  wire logic          last,
  output hfc_pkg::dec_t      dec
);
  logic [7:0]  e;
  logic [7:0]  sh;
  logic [4:0]  sh5;
  logic [23:0] sig;
  logic [23:0] shq;
  logic [23:0] mask;
  logic [9:0]  hm;
  logic [3:0]  p;
  always_comb begin
    e = data[30:23];
    sh = 8'd126 - e;
    sh5 = sh[4:0];
    sig = {1'b1, data[22:0]};
    shq = sig >> sh5;
    mask = (24'd1 << sh5) - 24'd1;
    hm = data[9:0];
    // leading one search over 10 bits
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (hm[i]) p = 4'(i);
    end
    dec = '0;
    dec.cmd = cmd;
    dec.last = last;
    dec.sign = (cmd == hfc_pkg::CMD_NARROW) ? data[31] : data[15];
    dec.exp = e;
    dec.frac = data[22:0];
    dec.h = data[15:0];
    dec.n_special = (e == 8'hFF);
    dec.n_nan = (e == 8'hFF) && (data[22:0] != '0);
    dec.n_ovf = (e >= 8'd143) && (e != 8'hFF);
    dec.n_normal = (e >= 8'd113) && (e < 8'd143);
    dec.n_zero = (e < 8'd102);
    dec.q = shq[14:0];
    dec.rem = sig & mask;
    dec.half = 24'd1 << (sh5 - 5'd1);
    dec.p = p;
    dec.mn = 10'(hm << (4'd10 - p));
  end
endmodule
`default_nettype wire

// ----- sv/hfc_round.sv -----
// ----------------------------------------------------------------------------
// hfc_round
// Stage 2: rounding decision and widened result assembly.
// ----------------------------------------------------------------------------
`default_nettype none
module hfc_round (
  input  wire hfc_pkg::dec_t dec,
  output hfc_pkg::res_t      res
);
  logic [14:0] base;
  logic [12:0] rem13;
  logic        nrm_inc;
  logic        sub_inc;
  logic [4:0]  he;
  logic [9:0]  hm;
  always_comb begin
    base    = {dec.exp[4:0] - 5'd16, dec.frac[22:13]};
    rem13   = dec.frac[12:0];
    nrm_inc = (rem13 > 13'h1000) || (rem13 == 13'h1000 && base[0]);
    sub_inc = (dec.rem > dec.half) || (dec.rem == dec.half && dec.q[0]);

    res      = '0;
    res.cmd  = dec.cmd;
    res.last = dec.last;
    res.sign = dec.sign;
    if (dec.n_special) begin
      res.npre = dec.n_nan ? (15'h7E00 | {5'd0, dec.frac[22:13]}) : 15'h7C00;
    end else if (dec.n_ovf) begin
      res.npre = 15'h7C00;
    end else if (dec.n_normal) begin
      res.npre = base;
      res.ninc = nrm_inc;
    end else if (dec.n_zero) begin
      res.npre = '0;
    end else begin
      res.npre = dec.q;
      res.ninc = sub_inc;
    end

    he = dec.h[14:10];
    hm = dec.h[9:0];
    if (he == 5'd31) begin
      res.wres = (hm == '0) ? 31'h7F800000 : (31'h7FC00000 | {8'd0, hm, 13'd0});
    end else if (he == 5'd0) begin
      res.wres = (hm == '0) ? 31'd0 : {8'(dec.p) + 8'd103, dec.mn, 13'd0};
    end else begin
      res.wres = {8'(he) + 8'd112, hm, 13'd0};
    end
  end
endmodule
`default_nettype wire

// ----- sv/half_float_converter_core.sv -----
// ----------------------------------------------------------------------------
// half_float_converter_core
// IEEE 754 binary32 <-> binary16 converter, three-stage pipeline.
// ----------------------------------------------------------------------------
// Converts one item per clock: cmd 0 narrows binary32 to binary16 (round to
// nearest even, subnormals, overflow to infinity, quiet NaN), cmd 1 widens
// binary16 (low 16 bits of data) to binary32 exactly. last passes through.
// The stages: stage 1 classifies and aligns (subnormal shift,
// leading-one search), stage 2 decides rounding and builds the widened
// result, stage 3 applies the round increment and picks the direction.
// The pipeline advances whenever the output stage is empty or being taken,
// so throughput is one item per cycle with a ready sink; back-pressure holds
// a full stage in place once every stage after it is full too.
`default_nettype none
module half_float_converter_core (
  input wire logic clk,
  input wire logic rst,
  hfc_if.sink      in_ch,
  hfc_if.source    out_ch
);
  hfc_pkg::dec_t dec_c, dec;
  hfc_pkg::res_t res_c, res;
  logic v1, v2, v3;
  logic [31:0] data_o;
  logic        last_o;
  logic adv3, adv2, adv1;
  logic [14:0] nres;
  logic [31:0] data_c;

  // each stage moves when its successor can take it
  assign adv3 = !v3 || out_ch.ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in_ch.ready = adv1;

  hfc_decode u_dec (.cmd(in_ch.cmd), .data(in_ch.data), .last(in_ch.last), .dec(dec_c));
  hfc_round  u_rnd (.dec(dec), .res(res_c));

  // stage 3: round increment (may carry into infinity) and direction select
  always_comb begin
    nres = res.npre + {14'd0, res.ninc};
    if (res.cmd == hfc_pkg::CMD_NARROW) begin
      data_c = {16'd0, res.sign, nres};
    end else begin
      data_c = {res.sign, res.wres};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_ch.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
    if (adv1) dec <= dec_c;
    if (adv2) res <= res_c;
    if (adv3) begin
      data_o <= data_c;
      last_o <= res.last;
    end
  end

  assign out_ch.valid = v3;
  assign out_ch.data  = data_o;
  assign out_ch.last  = last_o;
  assign out_ch.cmd   = 1'b0;
endmodule
`default_nettype wire
